// ===== hdl/stable_power_window_qualifier_defines.svh =====
// Assertion macros for the stable power window qualifier.
`ifndef STABLE_POWER_WINDOW_QUALIFIER_DEFINES_SVH
`define STABLE_POWER_WINDOW_QUALIFIER_DEFINES_SVH

`ifndef SYNTH
// Checks a property that must hold at every clock edge out of reset.
`define SPWQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("spwq assertion failed");
// Checks that a condition is followed by a consequence in the next cycle.
`define SPWQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spwq assertion failed");
`else
`define SPWQ_ASSERT(lbl, prop)
`define SPWQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/spwq_pkg.sv =====
// Types, codes and constants shared by the stable power window qualifier.
`default_nettype none
package spwq_pkg;

	localparam int unsigned WINDOW_SAMPLES_DEF = 8;

	localparam logic [11:0] WATT_FLOOR = 12'd10;
	localparam logic [11:0] SPAN_FLOOR = 12'd20;
	localparam logic [3:0]  SPAN_NUM   = 4'd15;
	localparam logic [7:0]  SPAN_DEN   = 8'd200;

	localparam logic [15:0] MAX_AGE_RST      = 16'd1500;
	localparam logic [15:0] SETTLE_RST       = 16'd3000;
	localparam logic [15:0] MIN_SPACING_RST  = 16'd700;
	localparam logic [15:0] POS_SPAN_RST     = 16'd100;
	localparam logic [7:0]  CAD_SPAN_RST     = 8'd5;
	localparam logic [7:0]  CAD_MIN_RST      = 8'd60;
	localparam logic [7:0]  CAD_MAX_RST      = 8'd120;
	localparam logic [11:0] WATT_CEILING_RST = 12'd1000;

	typedef enum logic [2:0] {
		REG_MAX_AGE      = 3'd0,
		REG_SETTLE       = 3'd1,
		REG_MIN_SPACING  = 3'd2,
		REG_POS_SPAN     = 3'd3,
		REG_CAD_SPAN     = 3'd4,
		REG_CAD_MIN      = 3'd5,
		REG_CAD_MAX      = 3'd6,
		REG_WATT_CEILING = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		CAUSE_NONE      = 4'd0,
		CAUSE_EPOCH     = 4'd1,
		CAUSE_DISABLED  = 4'd2,
		CAUSE_UNCERTAIN = 4'd3,
		CAUSE_SIMULATED = 4'd4,
		CAUSE_CADENCE   = 4'd5,
		CAUSE_STALE     = 4'd6,
		CAUSE_POWER     = 4'd7,
		CAUSE_GAP       = 4'd8,
		CAUSE_TRAVEL    = 4'd9,
		CAUSE_POS_SPAN  = 4'd10,
		CAUSE_CAD_SPAN  = 4'd11,
		CAUSE_PWR_SPAN  = 4'd12
	} cause_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic [31:0]        report_time_ms;
		logic [11:0]        power_watts;
		logic               power_simulated;
		logic [7:0]         cadence_rpm;
		logic               learn_enable;
		logic               coords_uncertain;
		logic [7:0]         coord_epoch;
		logic signed [31:0] motor_position;
		logic signed [31:0] motor_target;
	} item_t;

	typedef struct packed {
		logic               sample_taken;
		logic               window_done;
		logic [15:0]        watts_sum;
		logic [11:0]        cadence_sum;
		logic signed [35:0] position_sum;
		logic [3:0]         reset_cause;
	} result_t;

	typedef struct packed {
		logic [15:0] max_age_ms;
		logic [15:0] settle_ms;
		logic [15:0] min_spacing_ms;
		logic [15:0] position_span_limit;
		logic [7:0]  cadence_span_limit;
		logic [7:0]  cadence_min;
		logic [7:0]  cadence_max;
		logic [11:0] watt_ceiling;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hdl/spwq_item_if.sv =====
// Input channel carrying one poll item.
`default_nettype none
interface spwq_item_if;
	logic               valid;
	logic               ready;
	spwq_pkg::item_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/spwq_result_if.sv =====
// Output channel carrying one result item.
`default_nettype none
interface spwq_result_if;
	logic               valid;
	logic               ready;
	spwq_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/spwq_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none
interface spwq_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/spwq_cfg.sv =====
// Configuration register bank.
`default_nettype none
module spwq_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [2:0]    wr_index,
	input  wire logic [15:0]   wr_data,
	output spwq_pkg::cfg_t     cfg
);

	spwq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_age_ms          <= spwq_pkg::MAX_AGE_RST;
			cfg_q.settle_ms           <= spwq_pkg::SETTLE_RST;
			cfg_q.min_spacing_ms      <= spwq_pkg::MIN_SPACING_RST;
			cfg_q.position_span_limit <= spwq_pkg::POS_SPAN_RST;
			cfg_q.cadence_span_limit  <= spwq_pkg::CAD_SPAN_RST;
			cfg_q.cadence_min         <= spwq_pkg::CAD_MIN_RST;
			cfg_q.cadence_max         <= spwq_pkg::CAD_MAX_RST;
			cfg_q.watt_ceiling        <= spwq_pkg::WATT_CEILING_RST;
		end else if (wr_en) begin
			case (spwq_pkg::cfg_idx_t'(wr_index))
				spwq_pkg::REG_MAX_AGE:      cfg_q.max_age_ms          <= wr_data;
				spwq_pkg::REG_SETTLE:       cfg_q.settle_ms           <= wr_data;
				spwq_pkg::REG_MIN_SPACING:  cfg_q.min_spacing_ms      <= wr_data;
				spwq_pkg::REG_POS_SPAN:     cfg_q.position_span_limit <= wr_data;
				spwq_pkg::REG_CAD_SPAN:     cfg_q.cadence_span_limit  <= wr_data[7:0];
				spwq_pkg::REG_CAD_MIN:      cfg_q.cadence_min         <= wr_data[7:0];
				spwq_pkg::REG_CAD_MAX:      cfg_q.cadence_max         <= wr_data[7:0];
				spwq_pkg::REG_WATT_CEILING: cfg_q.watt_ceiling        <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/spwq_core.sv =====
// Qualification state and the single-pass decision logic for one poll.
`default_nettype none
module spwq_core #(
	parameter int unsigned WINDOW_SAMPLES = spwq_pkg::WINDOW_SAMPLES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  spwq_pkg::item_t    item,
	input  spwq_pkg::cfg_t     cfg,
	output spwq_pkg::result_t  res
);

	localparam int unsigned CW = $clog2(WINDOW_SAMPLES + 1);
	localparam logic [CW-1:0] LAST_COUNT = CW'(WINDOW_SAMPLES - 1);

	// Qualification state
	logic               seen_q, stable_q;
	logic [31:0]        last_rep_q, start_q, last_acc_q;
	logic [7:0]         epoch_q, clo_q, chi_q;
	logic signed [31:0] plo_q, phi_q;
	logic [CW-1:0]      count_q;
	// Running aggregates over the samples stored in the current window
	logic [11:0]        wlo_q, whi_q;
	logic [15:0]        wacc_q;
	logic [11:0]        cacc_q;
	logic signed [35:0] pacc_q;

	logic               seen_d, stable_d;
	logic [31:0]        last_rep_d, start_d, last_acc_d;
	logic [7:0]         epoch_d, clo_d, chi_d;
	logic signed [31:0] plo_d, phi_d;
	logic [CW-1:0]      count_d;
	logic [11:0]        wlo_d, whi_d;
	logic [15:0]        wacc_d;
	logic [11:0]        cacc_d;
	logic signed [35:0] pacc_d;

	logic               fresh, gap, epoch_chg, stable_eff;
	spwq_pkg::cause_t   early_cause, cause;
	logic signed [32:0] travel_sd;
	logic [32:0]        travel_abs;
	logic               travel_big;
	logic signed [31:0] plo_upd, phi_upd;
	logic [7:0]         clo_upd, chi_upd;
	logic [32:0]        pos_span;
	logic               pos_span_big, cad_span_big;
	logic [31:0]        since_start, since_now, since_acc;
	logic               sample_ok;
	logic [11:0]        wlo_upd, whi_upd, wdiff;
	logic [12:0]        wtotal;
	logic [19:0]        wdiff_scaled;
	logic [16:0]        wtotal_scaled;
	logic               pwr_span_big;
	logic               window_full;

	assign fresh     = !seen_q || (item.report_time_ms != last_rep_q);
	assign gap       = seen_q && ((item.report_time_ms - last_rep_q) > {16'd0, cfg.max_age_ms});
	assign epoch_chg = epoch_q != item.coord_epoch;
	// Gap and epoch restarts happen before the span logic sees the window.
	assign stable_eff = stable_q && !epoch_chg && !gap;

	always_comb begin
		if (!item.learn_enable) begin
			early_cause = spwq_pkg::CAUSE_DISABLED;
		end else if (item.coords_uncertain) begin
			early_cause = spwq_pkg::CAUSE_UNCERTAIN;
		end else if (item.power_simulated) begin
			early_cause = spwq_pkg::CAUSE_SIMULATED;
		end else if (item.cadence_rpm < cfg.cadence_min || item.cadence_rpm > cfg.cadence_max) begin
			early_cause = spwq_pkg::CAUSE_CADENCE;
		end else if ((item.now_ms - item.report_time_ms) > {16'd0, cfg.max_age_ms}) begin
			early_cause = spwq_pkg::CAUSE_STALE;
		end else if (item.power_watts <= spwq_pkg::WATT_FLOOR ||
			item.power_watts >= cfg.watt_ceiling) begin
			early_cause = spwq_pkg::CAUSE_POWER;
		end else begin
			early_cause = spwq_pkg::CAUSE_NONE;
		end
	end

	assign travel_sd  = 33'(item.motor_target) - 33'(item.motor_position);
	assign travel_abs = travel_sd[32] ? 33'(-travel_sd) : 33'(travel_sd);
	assign travel_big = travel_abs > {17'd0, cfg.position_span_limit};

	assign plo_upd = (item.motor_position < plo_q) ? item.motor_position : plo_q;
	assign phi_upd = (item.motor_position > phi_q) ? item.motor_position : phi_q;
	assign clo_upd = (item.cadence_rpm < clo_q) ? item.cadence_rpm : clo_q;
	assign chi_upd = (item.cadence_rpm > chi_q) ? item.cadence_rpm : chi_q;
	assign pos_span = 33'(33'(phi_upd) - 33'(plo_upd));
	assign pos_span_big = pos_span > {17'd0, cfg.position_span_limit};
	assign cad_span_big = (chi_upd - clo_upd) > cfg.cadence_span_limit;

	assign since_start = item.report_time_ms - start_q;
	assign since_now   = item.now_ms - start_q;
	assign since_acc   = item.report_time_ms - last_acc_q;
	assign sample_ok = fresh && (since_start >= {16'd0, cfg.settle_ms}) &&
		(since_start <= since_now) &&
		!((count_q != '0) && (since_acc < {16'd0, cfg.min_spacing_ms}));

	// Power spread test: diff > floor(total * 15 / 200) is the same as
	// diff * 200 > total * 15, so no divider is needed.
	assign wlo_upd = (count_q == '0 || item.power_watts < wlo_q) ? item.power_watts : wlo_q;
	assign whi_upd = (count_q == '0 || item.power_watts > whi_q) ? item.power_watts : whi_q;
	assign wdiff   = whi_upd - wlo_upd;
	assign wtotal  = 13'(wlo_upd) + 13'(whi_upd);
	assign wdiff_scaled  = 20'(wdiff) * 20'(spwq_pkg::SPAN_DEN);
	assign wtotal_scaled = 17'(wtotal) * 17'(spwq_pkg::SPAN_NUM);
	assign pwr_span_big  = (wdiff > spwq_pkg::SPAN_FLOOR) &&
		(wdiff_scaled > 20'(wtotal_scaled));

	assign window_full = count_q == LAST_COUNT;

	always_comb begin
		seen_d     = 1'b1;
		last_rep_d = item.report_time_ms;
		epoch_d    = item.coord_epoch;
		stable_d   = stable_q;
		start_d    = start_q;
		last_acc_d = last_acc_q;
		plo_d      = plo_q;
		phi_d      = phi_q;
		clo_d      = clo_q;
		chi_d      = chi_q;
		count_d    = count_q;
		wlo_d      = wlo_q;
		whi_d      = whi_q;
		wacc_d     = wacc_q;
		cacc_d     = cacc_q;
		pacc_d     = pacc_q;
		cause      = spwq_pkg::CAUSE_NONE;
		res        = '0;

		if (epoch_chg) begin
			cause    = spwq_pkg::CAUSE_EPOCH;
			count_d  = '0;
			stable_d = 1'b0;
		end

		if (early_cause != spwq_pkg::CAUSE_NONE) begin
			cause    = early_cause;
			count_d  = '0;
			stable_d = 1'b0;
		end else begin
			if (gap) begin
				cause    = spwq_pkg::CAUSE_GAP;
				count_d  = '0;
				stable_d = 1'b0;
			end
			if (travel_big) begin
				cause    = spwq_pkg::CAUSE_TRAVEL;
				count_d  = '0;
				stable_d = 1'b0;
			end else if (!stable_eff || pos_span_big || cad_span_big) begin
				// A span restart falls straight into a fresh stable window.
				if (stable_eff) begin
					cause = pos_span_big ? spwq_pkg::CAUSE_POS_SPAN : spwq_pkg::CAUSE_CAD_SPAN;
				end
				stable_d = 1'b1;
				start_d  = item.now_ms;
				count_d  = '0;
				plo_d    = item.motor_position;
				phi_d    = item.motor_position;
				clo_d    = item.cadence_rpm;
				chi_d    = item.cadence_rpm;
			end else begin
				plo_d = plo_upd;
				phi_d = phi_upd;
				clo_d = clo_upd;
				chi_d = chi_upd;
				if (sample_ok) begin
					if (pwr_span_big) begin
						cause    = spwq_pkg::CAUSE_PWR_SPAN;
						count_d  = '0;
						stable_d = 1'b0;
					end else begin
						res.sample_taken = 1'b1;
						last_acc_d = item.report_time_ms;
						wlo_d      = wlo_upd;
						whi_d      = whi_upd;
						if (count_q == '0) begin
							wacc_d = 16'(item.power_watts);
							cacc_d = 12'(item.cadence_rpm);
							pacc_d = 36'(item.motor_position);
						end else begin
							wacc_d = wacc_q + 16'(item.power_watts);
							cacc_d = cacc_q + 12'(item.cadence_rpm);
							pacc_d = pacc_q + 36'(item.motor_position);
						end
						if (window_full) begin
							res.window_done  = 1'b1;
							res.watts_sum    = wacc_d;
							res.cadence_sum  = cacc_d;
							res.position_sum = pacc_d;
							count_d = '0;
							plo_d   = item.motor_position;
							phi_d   = item.motor_position;
							clo_d   = item.cadence_rpm;
							chi_d   = item.cadence_rpm;
						end else begin
							count_d = count_q + 1'b1;
						end
					end
				end
			end
		end

		res.reset_cause = cause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			stable_q   <= 1'b0;
			last_rep_q <= '0;
			start_q    <= '0;
			last_acc_q <= '0;
			epoch_q    <= '0;
			clo_q      <= '0;
			chi_q      <= '0;
			plo_q      <= '0;
			phi_q      <= '0;
			count_q    <= '0;
		end else if (step) begin
			seen_q     <= seen_d;
			stable_q   <= stable_d;
			last_rep_q <= last_rep_d;
			start_q    <= start_d;
			last_acc_q <= last_acc_d;
			epoch_q    <= epoch_d;
			clo_q      <= clo_d;
			chi_q      <= chi_d;
			plo_q      <= plo_d;
			phi_q      <= phi_d;
			count_q    <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			wlo_q  <= wlo_d;
			whi_q  <= whi_d;
			wacc_q <= wacc_d;
			cacc_q <= cacc_d;
			pacc_q <= pacc_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/stable_power_window_qualifier.sv =====
// A result passes through the input register and then the result register after its item's transfer.
// One item per cycle while the result side is not stalled; the window state is computed in one combinational pass.
// The input stage keeps taking items while a result waits, until both registers are full.
// Reset (arst_n low, asynchronous) empties both stages, clears the window state
// and loads the configuration registers with their default values.
`default_nettype none
`include "stable_power_window_qualifier_defines.svh"
module stable_power_window_qualifier #(
	parameter int unsigned WINDOW_SAMPLES = spwq_pkg::WINDOW_SAMPLES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	spwq_cfg_if.sink      cfg,
	spwq_item_if.sink     item,
	spwq_result_if.source result
);

	spwq_pkg::item_t   item_s1;
	logic              valid_s1;
	spwq_pkg::result_t res_q;
	logic              out_valid_q;
	spwq_pkg::result_t res_next;
	spwq_pkg::cfg_t    cfg_val;
	logic              advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	spwq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.cfg      (cfg_val)
	);

	spwq_core #(
		.WINDOW_SAMPLES (WINDOW_SAMPLES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_val),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			out_valid_q <= advance || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	`SPWQ_ASSERT(a_stall_only_when_full, !item.ready |-> (valid_s1 && out_valid_q && !result.ready))
	`SPWQ_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_q)
	`SPWQ_ASSERT(a_done_implies_taken, result.valid && result.data.window_done |-> result.data.sample_taken)
	`SPWQ_ASSERT(a_sums_only_when_done, result.valid && !result.data.window_done |-> (result.data.watts_sum == '0 && result.data.cadence_sum == '0 && result.data.position_sum == '0))

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the stable power window qualifier: directed polls, then random rides.
module tb;
	import spwq_pkg::*;

	localparam int WIN = WINDOW_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES = 10;

	// Ways a random poll departs from a clean ride.
	typedef enum int {
		FLAW_NONE,
		FLAW_DISABLE,
		FLAW_UNCERTAIN,
		FLAW_SIMULATED,
		FLAW_CADENCE,
		FLAW_STALE,
		FLAW_WATTS,
		FLAW_GAP,
		FLAW_TRAVEL,
		FLAW_POS_JUMP,
		FLAW_CAD_JUMP,
		FLAW_WATT_JUMP,
		FLAW_EPOCH,
		FLAW_REPEAT,
		FLAW_LATE_NOW
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n;

	spwq_cfg_if    cfg_bus ();
	spwq_item_if   poll_bus ();
	spwq_result_if verdict_bus ();

	stable_power_window_qualifier i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (poll_bus),
		.result (verdict_bus)
	);

	always #4 clk = ~clk;

	// Settings as the block holds them.
	cfg_t settings_now = '{
		max_age_ms: MAX_AGE_RST, settle_ms: SETTLE_RST,
		min_spacing_ms: MIN_SPACING_RST, position_span_limit: POS_SPAN_RST,
		cadence_span_limit: CAD_SPAN_RST, cadence_min: CAD_MIN_RST,
		cadence_max: CAD_MAX_RST, watt_ceiling: WATT_CEILING_RST
	};

	// Window state mirrored from the block.
	logic        seen_report = 1'b0;
	logic [31:0] last_rep_ms = '0;
	logic [7:0]  held_epoch = '0;
	logic        stable = 1'b0;
	logic [31:0] stable_since_ms = '0;
	logic [31:0] last_store_ms = '0;
	longint      pos_lo = 0, pos_hi = 0;
	int          cad_lo = 0, cad_hi = 0;
	int          stored_count = 0;
	int unsigned win_watts [WIN];
	int unsigned win_cad [WIN];
	longint      win_pos [WIN];

	item_t   pending_polls[$];
	result_t expected_verdicts[$];
	int      polls_offered = 0;
	int      polls_accepted = 0;
	int      errors = 0;
	int      cycles = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Random ride state.
	logic [31:0] ride_t;
	int          ride_left = 0;
	logic [7:0]  ride_epoch = '0;
	int          ride_watts, ride_cad, ride_pos;
	int          step_lo = 100, step_hi = 600;

	function automatic cause_t drop_window(input cause_t code);
		stored_count = 0;
		stable = 1'b0;
		return code;
	endfunction

	function automatic void qualify_poll(input item_t p, output result_t r);
		logic [31:0]  since;
		longint       pos, tgt, trav, psum;
		int unsigned  lo, hi, bound, wsum, csum;
		logic         fresh, gap;
		r = '0;
		pos = p.motor_position;
		tgt = p.motor_target;
		fresh = !seen_report || p.report_time_ms != last_rep_ms;
		gap = seen_report && (p.report_time_ms - last_rep_ms) > settings_now.max_age_ms;
		seen_report = 1'b1;
		last_rep_ms = p.report_time_ms;

		if (held_epoch != p.coord_epoch) begin
			r.reset_cause = drop_window(CAUSE_EPOCH);
			held_epoch = p.coord_epoch;
		end
		if (!p.learn_enable) begin
			r.reset_cause = drop_window(CAUSE_DISABLED);
			return;
		end
		if (p.coords_uncertain) begin
			r.reset_cause = drop_window(CAUSE_UNCERTAIN);
			return;
		end
		if (p.power_simulated) begin
			r.reset_cause = drop_window(CAUSE_SIMULATED);
			return;
		end
		if (p.cadence_rpm < settings_now.cadence_min
				|| p.cadence_rpm > settings_now.cadence_max) begin
			r.reset_cause = drop_window(CAUSE_CADENCE);
			return;
		end
		if (p.now_ms - p.report_time_ms > settings_now.max_age_ms) begin
			r.reset_cause = drop_window(CAUSE_STALE);
			return;
		end
		if (p.power_watts <= WATT_FLOOR || p.power_watts >= settings_now.watt_ceiling) begin
			r.reset_cause = drop_window(CAUSE_POWER);
			return;
		end
		if (gap)
			r.reset_cause = drop_window(CAUSE_GAP);

		trav = tgt - pos;
		if (trav < 0)
			trav = -trav;
		if (trav > longint'(settings_now.position_span_limit)) begin
			r.reset_cause = drop_window(CAUSE_TRAVEL);
			return;
		end

		if (stable) begin
			if (pos < pos_lo) pos_lo = pos;
			if (pos > pos_hi) pos_hi = pos;
			if (p.cadence_rpm < cad_lo) cad_lo = p.cadence_rpm;
			if (p.cadence_rpm > cad_hi) cad_hi = p.cadence_rpm;
			if (pos_hi - pos_lo > longint'(settings_now.position_span_limit))
				r.reset_cause = drop_window(CAUSE_POS_SPAN);
			else if (cad_hi - cad_lo > int'(settings_now.cadence_span_limit))
				r.reset_cause = drop_window(CAUSE_CAD_SPAN);
		end
		if (!stable) begin
			stable = 1'b1;
			stable_since_ms = p.now_ms;
			pos_lo = pos;
			pos_hi = pos;
			cad_lo = p.cadence_rpm;
			cad_hi = p.cadence_rpm;
			return;
		end

		// Settle time, timestamps before the window start, and sample spacing.
		since = p.report_time_ms - stable_since_ms;
		if (!fresh || since < settings_now.settle_ms || since > p.now_ms - stable_since_ms
				|| (stored_count != 0
				&& p.report_time_ms - last_store_ms < settings_now.min_spacing_ms))
			return;

		lo = p.power_watts;
		hi = p.power_watts;
		for (int i = 0; i < stored_count; i++) begin
			if (win_watts[i] < lo) lo = win_watts[i];
			if (win_watts[i] > hi) hi = win_watts[i];
		end
		bound = (hi + lo) * SPAN_NUM / SPAN_DEN;
		if (bound < SPAN_FLOOR)
			bound = SPAN_FLOOR;
		if (hi - lo > bound) begin
			r.reset_cause = drop_window(CAUSE_PWR_SPAN);
			return;
		end

		win_watts[stored_count] = p.power_watts;
		win_cad[stored_count] = p.cadence_rpm;
		win_pos[stored_count] = pos;
		stored_count++;
		last_store_ms = p.report_time_ms;
		r.sample_taken = 1'b1;

		if (stored_count >= WIN) begin
			wsum = 0;
			csum = 0;
			psum = 0;
			for (int i = 0; i < WIN; i++) begin
				wsum += win_watts[i];
				csum += win_cad[i];
				psum += win_pos[i];
			end
			r.window_done = 1'b1;
			r.watts_sum = wsum[15:0];
			r.cadence_sum = csum[11:0];
			r.position_sum = psum[35:0];
			stored_count = 0;
			pos_lo = pos;
			pos_hi = pos;
			cad_lo = p.cadence_rpm;
			cad_hi = p.cadence_rpm;
		end
	endfunction

	task automatic check_field(input string name, input logic [35:0] want, input logic [35:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result checking comes before prediction, so the store is updated in a fixed order.
	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("stable_power_window_qualifier test failed");
			$finish;
		end else if (arst_n) begin
			if (verdict_bus.valid && verdict_bus.ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0h",
						$time, verdict_bus.data);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("sample_taken", want.sample_taken, verdict_bus.data.sample_taken);
					check_field("window_done", want.window_done, verdict_bus.data.window_done);
					check_field("watts_sum", want.watts_sum, verdict_bus.data.watts_sum);
					check_field("cadence_sum", want.cadence_sum, verdict_bus.data.cadence_sum);
					check_field("position_sum", want.position_sum,
						verdict_bus.data.position_sum);
					check_field("reset_cause", want.reset_cause, verdict_bus.data.reset_cause);
				end
			end
			if (poll_bus.valid && poll_bus.ready) begin
				qualify_poll(poll_bus.data, want);
				expected_verdicts.push_back(want);
				polls_accepted++;
			end
		end
	end

	// Poll driver: holds an offered poll until its transfer, otherwise idles or offers the next.
	always @(negedge clk) begin
		if (!arst_n)
			poll_bus.valid <= 1'b0;
		else if (polls_offered == polls_accepted) begin
			if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				poll_bus.data <= pending_polls.pop_front();
				poll_bus.valid <= 1'b1;
				polls_offered++;
			end else begin
				poll_bus.valid <= 1'b0;
			end
		end
	end

	// Result receiver, with a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			verdict_bus.ready <= 1'b0;
		end else begin
			verdict_bus.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic item_t mk_poll(input logic [31:0] now, input logic [31:0] rep,
			input logic [11:0] watts, input logic sim, input logic [7:0] cad,
			input logic learn, input logic unc, input logic [7:0] epoch,
			input int pos, input int tgt);
		item_t p;
		p.now_ms = now;
		p.report_time_ms = rep;
		p.power_watts = watts;
		p.power_simulated = sim;
		p.cadence_rpm = cad;
		p.learn_enable = learn;
		p.coords_uncertain = unc;
		p.coord_epoch = epoch;
		p.motor_position = pos;
		p.motor_target = tgt;
		return p;
	endfunction

	function automatic int pick_watts();
		if (settings_now.watt_ceiling > 60)
			return $urandom_range(40, settings_now.watt_ceiling - 20);
		return $urandom_range(4095);
	endfunction

	task automatic wait_drained();
		while (pending_polls.size() != 0 || polls_offered != polls_accepted
				|| expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_MAX_AGE:      settings_now.max_age_ms = value;
			REG_SETTLE:       settings_now.settle_ms = value;
			REG_MIN_SPACING:  settings_now.min_spacing_ms = value;
			REG_POS_SPAN:     settings_now.position_span_limit = value;
			REG_CAD_SPAN:     settings_now.cadence_span_limit = value[7:0];
			REG_CAD_MIN:      settings_now.cadence_min = value[7:0];
			REG_CAD_MAX:      settings_now.cadence_max = value[7:0];
			REG_WATT_CEILING: settings_now.watt_ceiling = value[11:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(REG_MAX_AGE, c.max_age_ms);
		write_reg(REG_SETTLE, c.settle_ms);
		write_reg(REG_MIN_SPACING, c.min_spacing_ms);
		write_reg(REG_POS_SPAN, c.position_span_limit);
		write_reg(REG_CAD_SPAN, {8'd0, c.cadence_span_limit});
		write_reg(REG_CAD_MIN, {8'd0, c.cadence_min});
		write_reg(REG_CAD_MAX, {8'd0, c.cadence_max});
		write_reg(REG_WATT_CEILING, {4'd0, c.watt_ceiling});
	endtask

	// Mostly clean rides with random content, some broken polls and some noise.
	task automatic queue_rides(input int count);
		item_t        p;
		logic [159:0] raw;
		flaw_t        flaw;
		int           mode, jit, lim;
		logic [31:0]  step;
		for (int n = 0; n < count; n++) begin
			if (ride_left == 0) begin
				ride_left = $urandom_range(20, 60);
				if ($urandom_range(3) == 0)
					ride_epoch = $urandom_range(255);
				ride_watts = pick_watts();
				if (settings_now.cadence_min <= settings_now.cadence_max)
					ride_cad = $urandom_range(settings_now.cadence_min, settings_now.cadence_max);
				else
					ride_cad = $urandom_range(255);
				ride_pos = $urandom;
			end
			ride_left--;
			lim = settings_now.position_span_limit;
			jit = (lim / 3 > 1000) ? 1000 : lim / 3;
			mode = $urandom_range(99);
			if (mode >= 95) begin
				raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
				p = raw[158:0];
			end else begin
				flaw = (mode >= 80) ? flaw_t'($urandom_range(FLAW_DISABLE, FLAW_LATE_NOW))
					: FLAW_NONE;
				step = $urandom_range(step_lo, step_hi);
				if (flaw == FLAW_GAP)
					step += settings_now.max_age_ms + 1;
				if (flaw == FLAW_REPEAT)
					step = 0;
				ride_t += step;
				case (flaw)
					FLAW_POS_JUMP: ride_pos += lim + 1 + int'($urandom_range(50));
					FLAW_CAD_JUMP: ride_cad = (ride_cad + settings_now.cadence_span_limit + 1) % 256;
					FLAW_WATT_JUMP: ride_watts = pick_watts();
					FLAW_EPOCH: ride_epoch++;
					default: ;
				endcase
				p.report_time_ms = ride_t;
				p.now_ms = ride_t + $urandom_range(0, settings_now.max_age_ms / 2);
				p.power_watts = ride_watts + int'($urandom_range(0, 8)) - 4;
				p.power_simulated = 1'b0;
				p.cadence_rpm = ride_cad + int'($urandom_range(0, 2)) - 1;
				p.learn_enable = 1'b1;
				p.coords_uncertain = 1'b0;
				p.coord_epoch = ride_epoch;
				p.motor_position = ride_pos + int'($urandom_range(0, 2 * jit)) - jit;
				p.motor_target = p.motor_position + int'($urandom_range(0, 2 * jit)) - jit;
				case (flaw)
					FLAW_DISABLE: p.learn_enable = 1'b0;
					FLAW_UNCERTAIN: p.coords_uncertain = 1'b1;
					FLAW_SIMULATED: p.power_simulated = 1'b1;
					FLAW_CADENCE: p.cadence_rpm = $urandom_range(255);
					FLAW_STALE: p.now_ms = ride_t + settings_now.max_age_ms + 1
						+ $urandom_range(100);
					FLAW_WATTS: p.power_watts = $urandom_range(4095);
					FLAW_TRAVEL:
						if ($urandom_range(1))
							p.motor_target = p.motor_position + lim + 1 + int'($urandom_range(50));
						else
							p.motor_target = p.motor_position - lim - 1 - int'($urandom_range(50));
					FLAW_POS_JUMP: p.motor_target = p.motor_position;
					FLAW_LATE_NOW: p.now_ms = ride_t + $urandom_range(0, settings_now.max_age_ms);
					default: ;
				endcase
			end
			pending_polls.push_back(p);
		end
	endtask

	task automatic run_phase(input cfg_t c, input int lo, input int hi, input int idle,
			input int stall, input int count);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		load_settings(c);
		step_lo = lo;
		step_hi = hi;
		queue_rides(count);
	endtask

	initial begin
		arst_n = 1'b0;
		poll_bus.valid = 1'b0;
		poll_bus.data = '0;
		verdict_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_MAX_AGE;
		cfg_bus.wdata = '0;
		ride_t = $urandom;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed polls under the reset settings.
		pending_polls.push_back(mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_polls.push_back(mk_poll('1, '1, 12'hFFF, 1, 8'hFF, 1, 1, 8'hFF,
			32'h7FFFFFFF, 32'h80000000));
		pending_polls.push_back(mk_poll(1000, 1000, 200, 1, 90, 1, 0, 255, 0, 0));
		pending_polls.push_back(mk_poll(1100, 1100, 200, 0, 59, 1, 0, 255, 0, 0));
		pending_polls.push_back(mk_poll(2701, 1200, 200, 0, 90, 1, 0, 255, 0, 0));
		pending_polls.push_back(mk_poll(1300, 1300, 10, 0, 90, 1, 0, 255, 0, 0));
		pending_polls.push_back(mk_poll(1400, 1400, 1000, 0, 90, 1, 0, 255, 0, 0));
		pending_polls.push_back(mk_poll(1500, 1500, 200, 0, 90, 1, 0, 255, 100, 201));
		pending_polls.push_back(mk_poll(2000, 2000, 200, 0, 90, 1, 0, 255, 1000, 900));
		// Same timestamp again, then settle and spacing.
		pending_polls.push_back(mk_poll(2100, 2000, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(3400, 3400, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(4800, 4800, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(5000, 5000, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(5500, 5500, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(5700, 5700, 260, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(6000, 6000, 200, 0, 90, 1, 0, 255, 1000, 1000));
		pending_polls.push_back(mk_poll(7000, 7000, 200, 0, 90, 1, 0, 255, 1101, 1101));
		pending_polls.push_back(mk_poll(9400, 8000, 200, 0, 96, 1, 0, 255, 1101, 1101));
		// The report predates the window start.
		pending_polls.push_back(mk_poll(9500, 8500, 200, 0, 96, 1, 0, 255, 1101, 1101));
		// Epoch change together with a gap, then with a missing permission.
		pending_polls.push_back(mk_poll(10500, 10500, 200, 0, 96, 1, 0, 7, 1101, 1101));
		pending_polls.push_back(mk_poll(10600, 10600, 200, 0, 96, 0, 0, 8, 1101, 1101));
		pending_polls.push_back(mk_poll(10700, 10700, 200, 0, 90, 1, 0, 8, 0, -101));
		pending_polls.push_back(mk_poll(10800, 10800, 11, 0, 60, 1, 0, 8, 0, 0));
		pending_polls.push_back(mk_poll(10900, 10900, 999, 0, 120, 1, 0, 8, 0, 0));

		run_phase('{max_age_ms: 1500, settle_ms: 3000, min_spacing_ms: 700,
			position_span_limit: 100, cadence_span_limit: 5, cadence_min: 60,
			cadence_max: 120, watt_ceiling: 1000}, 100, 600, 0, 0, 250);
		run_phase('{max_age_ms: 1000, settle_ms: 0, min_spacing_ms: 0,
			position_span_limit: 50, cadence_span_limit: 3, cadence_min: 0,
			cadence_max: 255, watt_ceiling: 4095}, 1, 400, 51, 0, 250);
		run_phase('{max_age_ms: 16'hFFFF, settle_ms: 16'hFFFF, min_spacing_ms: 16'hFFFF,
			position_span_limit: 16'hFFFF, cadence_span_limit: 8'hFF, cadence_min: 8'hFF,
			cadence_max: 8'hFF, watt_ceiling: 12'hFFF}, 1000, 20000, 0, 51, 100);
		run_phase('{max_age_ms: 0, settle_ms: 0, min_spacing_ms: 0,
			position_span_limit: 0, cadence_span_limit: 0, cadence_min: 0,
			cadence_max: 0, watt_ceiling: 0}, 0, 3, 17, 17, 60);
		// Crossed cadence bounds reject every poll.
		run_phase('{max_age_ms: 1500, settle_ms: 100, min_spacing_ms: 50,
			position_span_limit: 100, cadence_span_limit: 5, cadence_min: 200,
			cadence_max: 100, watt_ceiling: 1000}, 10, 100, 17, 17, 40);
		run_phase('{max_age_ms: 800, settle_ms: 500, min_spacing_ms: 200,
			position_span_limit: 30, cadence_span_limit: 2, cadence_min: 80,
			cadence_max: 90, watt_ceiling: 600}, 20, 300, 17, 17, 120);
		// The receiver holds off while polls keep coming, so the block backs up.
		hold_requests++;
		wait_drained();
		queue_rides(130);

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("stable_power_window_qualifier test passed");
		else
			$display("stable_power_window_qualifier test failed");
		$finish;
	end

endmodule

// ===== stable_power_window_qualifier.f =====
+incdir+hdl
hdl/spwq_pkg.sv
hdl/spwq_item_if.sv
hdl/spwq_result_if.sv
hdl/spwq_cfg_if.sv
hdl/spwq_cfg.sv
hdl/spwq_core.sv
hdl/stable_power_window_qualifier.sv
tb/tb.sv
